[rtl/cfa_pkg.sv]
// ---------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the contiguous frame allocator
// Field widths, operation, status and register codes, and the sequencer
// state type.
// ---------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 1024;

  localparam int OP_W     = 1;
  localparam int CNT_W    = 11;
  localparam int FRAME_W  = 10;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // reuse map is kept as words of this many frames
  localparam int MAP_WORD_W  = 8;
  localparam int MAP_WORD_LG = $clog2(MAP_WORD_W);

  // value of a reuse-map bit
  localparam logic MAP_INUSE    = 1'b0;
  localparam logic MAP_REUSABLE = 1'b1;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOROOM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLE  = 2'd2;

  localparam logic [CNT_W-1:0] FRAMES_IN_USE_RST = 11'd1024;
  localparam logic [CNT_W-1:0] FIRST_UNUSED_RST  = 11'd0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_BUMP,
    S_FREE_CHK,
    S_FILL,
    S_RESP
  } cfa_state_t;

endpackage

`default_nettype wire

[rtl/cfa_if.sv]
// ---------------------------------------------------------------------------
// cfa_if: channel interfaces of the contiguous frame allocator
// Request, response and configuration write channels, each with valid,
// ready and payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfa_in_if;
  import cfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CNT_W-1:0]    page_count;
  logic [FRAME_W-1:0]  start_frame;

  modport source (output valid, output op, output page_count, output start_frame,
                  input ready);
  modport sink   (input valid, input op, input page_count, input start_frame,
                  output ready);
endinterface

interface cfa_out_if;
  import cfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  frame;

  modport source (output valid, output status, output frame, input ready);
  modport sink   (input valid, input status, input frame, output ready);
endinterface

interface cfa_cfg_if;
  import cfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/contiguous_frame_allocator.sv]
// ---------------------------------------------------------------------------
// contiguous_frame_allocator: first-fit contiguous frame allocator
// Allocates runs of adjacent physical frames from a reuse map, falling
// back to a bump pointer, and returns freed runs to the reuse map.
// ---------------------------------------------------------------------------
// Usage:
//   in_req  : one request per transfer. op selects allocate (page_count
//             frames) or free (run recorded at start_frame).
//   out_rsp : one response per request, status and first granted frame.
//   cfg_wr  : register writes (0 frames_in_use, 1 first_unused_frame,
//             2 table_enable), always ready; write only while idle.
// Timing: one request at a time; in_req.ready is high only when idle.
//   The reuse map sits in a RAM of 8-frame words; scan and mark/free move
//   one word a cycle. With the table on, an allocate scans words up to
//   the hit (all words below the limit on a miss), then marks the words
//   the run spans or, on a miss, tries the bump pointer; with the table
//   off it goes to the bump pointer at once. A free checks the recorded
//   run and marks its words reusable; a zero-size allocate or an invalid
//   free is refused at once.
// Response: registered; the next request is accepted while a response
//   still waits. If out_rsp stalls, the sequencer holds its finished
//   result until the output register frees up.
// Reset: after rst_n a clearing pass of NUM_FRAMES cycles zeroes the reuse
//   map and the run-length table; no request is accepted meanwhile, but
//   configuration writes are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module contiguous_frame_allocator #(
  parameter int unsigned NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cfa_in_if.sink     in_req,
  cfa_out_if.source  out_rsp,
  cfa_cfg_if.sink    cfg_wr
);

  import cfa_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NW    = (NUM_FRAMES + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int WA_W  = (NW > 1) ? $clog2(NW) : 1;
  // position width: holds frame numbers, limits and start + length sums
  localparam int PW    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 2;

  localparam logic [PW-1:0] NF_P = PW'(NUM_FRAMES);
  localparam logic [PW-1:0] NW_P = PW'(NW);
  localparam logic [PW-1:0] WW_P = PW'(MAP_WORD_W);

  // ---------------- storage ----------------
  logic [MAP_WORD_W-1:0] map_mem [NW];
  logic [CNT_W-1:0]      rl_mem  [NUM_FRAMES];

  logic                  map_we;
  logic [WA_W-1:0]       map_wa, map_ra;
  logic [MAP_WORD_W-1:0] map_wd, map_q;
  logic                  rl_we;
  logic [IDX_W-1:0]      rl_wa, rl_ra;
  logic [CNT_W-1:0]      rl_wd, rl_q;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (rl_we) rl_mem[rl_wa] <= rl_wd;
    rl_q <= rl_mem[rl_ra];
  end

  // ---------------- registers ----------------
  cfa_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]     fiu_r, fiu_nxt;          // frames_in_use
  logic                 te_r, te_nxt;            // table_enable
  logic [CNT_W-1:0]     bump_r, bump_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic                 f_more_r, f_more_nxt;
  logic                 wb_valid_r, wb_valid_nxt;

  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [FRAME_W-1:0]   s_r, s_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt;
  logic [WA_W-1:0]      rd_word_r, rd_word_nxt;
  logic [WA_W-1:0]      ev_word_r, ev_word_nxt;
  logic [PW-1:0]        lo_r, lo_nxt;
  logic [PW-1:0]        hi_r, hi_nxt;
  logic                 fill_val_r, fill_val_nxt;
  logic [WA_W-1:0]      f_rd_r, f_rd_nxt;
  logic [WA_W-1:0]      f_last_r, f_last_nxt;
  logic [WA_W-1:0]      wb_word_r, wb_word_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]   res_frame_r, res_frame_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fiu_r       <= FRAMES_IN_USE_RST;
      te_r        <= 1'b1;
      bump_r      <= FIRST_UNUSED_RST;
      out_valid_r <= 1'b0;
      ev_valid_r  <= 1'b0;
      f_more_r    <= 1'b0;
      wb_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fiu_r       <= fiu_nxt;
      te_r        <= te_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
      ev_valid_r  <= ev_valid_nxt;
      f_more_r    <= f_more_nxt;
      wb_valid_r  <= wb_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    s_r          <= s_nxt;
    cnt_r        <= cnt_nxt;
    rd_word_r    <= rd_word_nxt;
    ev_word_r    <= ev_word_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    fill_val_r   <= fill_val_nxt;
    f_rd_r       <= f_rd_nxt;
    f_last_r     <= f_last_nxt;
    wb_word_r    <= wb_word_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  // ---------------- derived values ----------------
  logic [PW-1:0] fiu_p, limit, n_p, s_p, s_in_p, bump_p, clr_p;
  assign fiu_p  = PW'(fiu_r);
  // frame limit: frames_in_use, capped at the table depth
  assign limit  = (fiu_p > NF_P) ? NF_P : fiu_p;
  assign n_p    = PW'(n_r);
  assign s_p    = PW'(s_r);
  assign s_in_p = PW'(in_req.start_frame);
  assign bump_p = PW'(bump_r);
  assign clr_p  = PW'(clr_r);

  // Scan unit: one map word a cycle, first-fit run count carried in cnt_r.
  logic [PW-1:0] ev_base, ev_cnt, ev_hit_pos, hit_start, hit_end;
  logic          ev_hit;
  assign ev_base = PW'(ev_word_r) << MAP_WORD_LG;

  always_comb begin : scan_eval
    logic [PW-1:0] c;
    logic [PW-1:0] pos;
    logic          vb;
    c          = cnt_r;
    ev_hit     = 1'b0;
    ev_hit_pos = '0;
    for (int j = 0; j < MAP_WORD_W; j++) begin
      pos = ev_base + PW'(j);
      vb  = (map_q[j] == MAP_REUSABLE) && (pos < limit);
      c   = vb ? c + PW'(1) : '0;
      if (vb && (c >= n_p) && !ev_hit) begin
        ev_hit     = 1'b1;
        ev_hit_pos = pos;
      end
    end
    ev_cnt = c;
  end

  assign hit_start = ev_hit_pos + PW'(1) - n_p;
  assign hit_end   = ev_hit_pos + PW'(1);

  // word span of the run to mark or free
  logic [PW-1:0] fr_sum, fr_hi, fr_first_w, fr_last_w, al_first_w, al_last_w;
  assign fr_sum     = s_p + PW'(rl_q);
  assign fr_hi      = (fr_sum > limit) ? limit : fr_sum;
  assign fr_first_w = s_p >> MAP_WORD_LG;
  assign fr_last_w  = (fr_hi - PW'(1)) >> MAP_WORD_LG;
  assign al_first_w = hit_start >> MAP_WORD_LG;
  assign al_last_w  = ev_hit_pos >> MAP_WORD_LG;

  // Read-modify-write of one map word: bits inside [lo, hi) take fill_val.
  logic [PW-1:0]         wb_base;
  logic [MAP_WORD_W-1:0] fill_data;
  assign wb_base = PW'(wb_word_r) << MAP_WORD_LG;

  always_comb begin : fill_merge
    logic [PW-1:0] pos;
    for (int j = 0; j < MAP_WORD_W; j++) begin
      pos          = wb_base + PW'(j);
      fill_data[j] = ((pos >= lo_r) && (pos < hi_r)) ? fill_val_r : map_q[j];
    end
  end

  // bump grant check
  logic bump_ok;
  assign bump_ok = (bump_p < limit) && (n_p <= (limit - bump_p));

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    fiu_nxt        = fiu_r;
    te_nxt         = te_r;
    bump_nxt       = bump_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    ev_valid_nxt   = ev_valid_r;
    f_more_nxt     = f_more_r;
    wb_valid_nxt   = wb_valid_r;
    n_nxt          = n_r;
    s_nxt          = s_r;
    cnt_nxt        = cnt_r;
    rd_word_nxt    = rd_word_r;
    ev_word_nxt    = ev_word_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    fill_val_nxt   = fill_val_r;
    f_rd_nxt       = f_rd_r;
    f_last_nxt     = f_last_r;
    wb_word_nxt    = wb_word_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;

    map_we = 1'b0;
    map_wa = '0;
    map_wd = '0;
    map_ra = '0;
    rl_we  = 1'b0;
    rl_wa  = '0;
    rl_wd  = '0;
    rl_ra  = '0;

    in_req.ready = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // zero one run-length entry and, while in range, one map word
        map_we  = (clr_p < NW_P);
        map_wa  = clr_r[WA_W-1:0];
        map_wd  = {MAP_WORD_W{MAP_INUSE}};
        rl_we   = 1'b1;
        rl_wa   = clr_r;
        rl_wd   = '0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NUM_FRAMES - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        in_req.ready = 1'b1;
        // fetch the recorded run length in case this is a free
        rl_ra = s_in_p[IDX_W-1:0];
        if (in_req.valid) begin
          n_nxt         = in_req.page_count;
          s_nxt         = in_req.start_frame;
          res_frame_nxt = '0;
          if (in_req.op == OP_ALLOC) begin
            if (in_req.page_count == '0) begin
              res_status_nxt = ST_NOROOM;
              state_nxt      = S_RESP;
            end else if (te_r) begin
              rd_word_nxt  = '0;
              ev_valid_nxt = 1'b0;
              cnt_nxt      = '0;
              state_nxt    = S_SCAN;
            end else begin
              state_nxt = S_BUMP;
            end
          end else begin
            if (!te_r || (s_in_p >= limit)) begin
              res_status_nxt = ST_BADFREE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FREE_CHK;
            end
          end
        end
      end

      S_FREE_CHK: begin
        if (rl_q == '0) begin
          res_status_nxt = ST_BADFREE;
          state_nxt      = S_RESP;
        end else begin
          lo_nxt         = s_p;
          hi_nxt         = fr_hi;
          fill_val_nxt   = MAP_REUSABLE;
          f_rd_nxt       = fr_first_w[WA_W-1:0];
          f_last_nxt     = fr_last_w[WA_W-1:0];
          f_more_nxt     = 1'b1;
          wb_valid_nxt   = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FILL;
        end
      end

      S_SCAN: begin
        // issue the next word read while the previous word is evaluated
        map_ra       = rd_word_r;
        rd_word_nxt  = rd_word_r + WA_W'(1);
        ev_word_nxt  = rd_word_r;
        ev_valid_nxt = 1'b1;
        if (ev_valid_r) begin
          if (ev_hit) begin
            rl_we          = 1'b1;
            rl_wa          = hit_start[IDX_W-1:0];
            rl_wd          = n_r;
            lo_nxt         = hit_start;
            hi_nxt         = hit_end;
            fill_val_nxt   = MAP_INUSE;
            f_rd_nxt       = al_first_w[WA_W-1:0];
            f_last_nxt     = al_last_w[WA_W-1:0];
            f_more_nxt     = 1'b1;
            wb_valid_nxt   = 1'b0;
            res_status_nxt = ST_OK;
            res_frame_nxt  = hit_start[FRAME_W-1:0];
            state_nxt      = S_FILL;
          end else if ((ev_base + WW_P) >= limit) begin
            state_nxt = S_BUMP;
          end else begin
            cnt_nxt = ev_cnt;
          end
        end
      end

      S_BUMP: begin
        if (bump_ok) begin
          if (te_r) begin
            rl_we = 1'b1;
            rl_wa = bump_p[IDX_W-1:0];
            rl_wd = n_r;
          end
          bump_nxt       = bump_r + n_r;
          res_status_nxt = ST_OK;
          res_frame_nxt  = bump_r[FRAME_W-1:0];
        end else begin
          res_status_nxt = ST_NOROOM;
          res_frame_nxt  = '0;
        end
        state_nxt = S_RESP;
      end

      S_FILL: begin
        if (f_more_r) begin
          map_ra       = f_rd_r;
          f_rd_nxt     = f_rd_r + WA_W'(1);
          f_more_nxt   = (f_rd_r != f_last_r);
          wb_word_nxt  = f_rd_r;
          wb_valid_nxt = 1'b1;
        end else begin
          wb_valid_nxt = 1'b0;
          state_nxt    = S_RESP;
        end
        if (wb_valid_r) begin
          map_we = 1'b1;
          map_wa = wb_word_r;
          map_wd = fill_data;
        end
      end

      S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration transfers, accepted in any state
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_FRAMES_IN_USE: fiu_nxt  = cfg_wr.data[CNT_W-1:0];
        CFG_FIRST_UNUSED:  bump_nxt = cfg_wr.data[CNT_W-1:0];
        CFG_TABLE_ENABLE:  te_nxt   = cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready   = 1'b1;
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.frame  = out_frame_r;

endmodule

`default_nettype wire
